// ===== src/hyperbolic_translation_matrix_defines.svh =====
`ifndef HYPERBOLIC_TRANSLATION_MATRIX_DEFINES_SVH
`define HYPERBOLIC_TRANSLATION_MATRIX_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define HTM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define HTM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/htm_pkg.sv =====
package htm_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam logic [1:0] ROW_LAST = 2'd3;

    typedef logic signed [31:0] word_t;
    typedef word_t vec_t [4];
    typedef vec_t mat_t [4];

    // exact product rounded half up to frac fraction bits
    function automatic logic signed [63:0] mulr(word_t a, word_t b, int frac);
        logic signed [63:0] t;
        t = 64'(a) * 64'(b);
        t = t + (64'sd1 <<< (frac - 1));
        return t >>> frac;
    endfunction

    function automatic word_t sat32(logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic word_t neg_sat(word_t v);
        return (v == 32'sh80000000) ? 32'sh7fffffff : -v;
    endfunction

    // one root bit per stage over a radicand of 31 + frac bits
    function automatic int sqrt_stages(int frac);
        return (32 + frac) / 2;
    endfunction

    // one quotient bit per stage for 2^(2*frac+1) / d
    function automatic int div_stages(int frac);
        return 2 * frac + 2;
    endfunction

endpackage

// ===== src/htm_sqrt.sv =====
module htm_sqrt #(
    parameter int FRAC_BITS = htm_pkg::FRAC_BITS_DEF,
    localparam int NST = htm_pkg::sqrt_stages(FRAC_BITS),
    localparam int RADW = 2 * NST
) (
    input  logic            clk,
    input  logic            en,
    input  logic [RADW-1:0] rad,
    output logic [NST-1:0]  root
);

    localparam int RW = NST + 3;

    logic [RW-1:0]   rem_reg  [NST];
    logic [NST-1:0]  root_reg [NST];
    logic [RADW-1:0] rad_reg  [NST];

    logic [RW-1:0]   rem_next  [NST];
    logic [NST-1:0]  root_next [NST];
    logic [RADW-1:0] rad_next  [NST];

    logic [RW-1:0]   rem_src  [NST];
    logic [NST-1:0]  root_src [NST];
    logic [RADW-1:0] rad_src  [NST];

    always_comb
    begin : p_src
        rem_src[0]  = '0;
        root_src[0] = '0;
        rad_src[0]  = rad;
        for (int k = 1; k < NST; k++)
        begin
            rem_src[k]  = rem_reg[k-1];
            root_src[k] = root_reg[k-1];
            rad_src[k]  = rad_reg[k-1];
        end
    end

    // restoring square root: bring down two radicand bits, try (root*4 + 1)
    always_comb
    begin : p_step
        logic [RW-1:0] sh;
        logic [RW-1:0] tr;
        logic          ge;
        for (int k = 0; k < NST; k++)
        begin
            sh           = {rem_src[k][RW-3:0], rad_src[k][RADW-1 -: 2]};
            tr           = RW'({root_src[k], 2'b01});
            ge           = (sh >= tr);
            rem_next[k]  = ge ? (sh - tr) : sh;
            root_next[k] = {root_src[k][NST-2:0], ge};
            rad_next[k]  = rad_src[k] << 2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NST; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= rad_next[k];
            end
        end
    end

    assign root = root_reg[NST-1];

endmodule

// ===== src/htm_div.sv =====
module htm_div #(
    parameter int FRAC_BITS = htm_pkg::FRAC_BITS_DEF,
    localparam int NST = htm_pkg::div_stages(FRAC_BITS)
) (
    input  logic           clk,
    input  logic           en,
    input  logic [31:0]    divisor,
    output logic [NST-1:0] quot
);

    // numerator is 2^(NST-1): only the first stage brings down a one
    logic [31:0]    rem_reg [NST];
    logic [NST-1:0] q_reg   [NST];
    logic [31:0]    d_reg   [NST];

    logic [31:0]    rem_next [NST];
    logic [NST-1:0] q_next   [NST];

    logic [31:0]    rem_src [NST];
    logic [NST-1:0] q_src   [NST];
    logic [31:0]    d_src   [NST];

    always_comb
    begin : p_src
        rem_src[0] = '0;
        q_src[0]   = '0;
        d_src[0]   = divisor;
        for (int k = 1; k < NST; k++)
        begin
            rem_src[k] = rem_reg[k-1];
            q_src[k]   = q_reg[k-1];
            d_src[k]   = d_reg[k-1];
        end
    end

    always_comb
    begin : p_step
        logic [32:0] rin;
        logic [32:0] dv;
        logic        ge;
        for (int k = 0; k < NST; k++)
        begin
            rin         = {rem_src[k], (k == 0) ? 1'b1 : 1'b0};
            dv          = {1'b0, d_src[k]};
            ge          = (rin >= dv);
            rem_next[k] = ge ? 32'(rin - dv) : rin[31:0];
            q_next[k]   = {q_src[k][NST-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NST; k++)
            begin
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
                d_reg[k]   <= d_src[k];
            end
        end
    end

    assign quot = q_reg[NST-1];

endmodule

// ===== src/hyperbolic_translation_matrix.sv =====
// Channel   Dir  Width  Carries
// s_axis    in   256    from point then to point, one transfer per item
// m_axis    out  128    one matrix row per transfer, four per item, tlast on row 3
//
// An item enters in any cycle where the pipeline may advance; each item leaves as four
// row transfers, one per cycle while m_axis_tready is high, so the single result channel
// sets the sustained item rate; a new item can enter before earlier ones have left. The
// latency is set mostly by the bit-per-stage square root and reciprocal units.
// rst_n clears only valid bits and the row counter. A stall on
// m_axis freezes the whole pipeline once its last stage holds an item; bubbles still move.
`include "hyperbolic_translation_matrix_defines.svh"

module hyperbolic_translation_matrix #(
    parameter int FRAC_BITS = htm_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // from_x, from_y, from_z, from_w, to_x, to_y, to_z, to_w (32 bits each)
    input  logic [255:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // entry_0, entry_1, entry_2, entry_3 (32 bits each)
    output logic [127:0] m_axis_tdata,
    // row_index [1:0], fault [2]
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    localparam int PW   = 64 - FRAC_BITS;
    localparam int SQL  = htm_pkg::sqrt_stages(FRAC_BITS);
    localparam int RADW = 2 * SQL;
    localparam int DVL  = htm_pkg::div_stages(FRAC_BITS);
    localparam int LAT  = 13 + SQL + DVL;
    localparam logic signed [63:0] ONE64 = 64'sd1 <<< FRAC_BITS;

    typedef logic signed [PW-1:0] prod_t;

    function automatic logic signed [63:0] sx(prod_t x);
        return 64'(x);
    endfunction

    function automatic htm_pkg::word_t mink(prod_t a [4]);
        return htm_pkg::sat32(sx(a[0]) + sx(a[1]) + sx(a[2]) - sx(a[3]));
    endfunction

    // signed, saturated -(2 << 2F) / d from the magnitude quotient
    function automatic htm_pkg::word_t to_scale(logic [DVL-1:0] mag, logic dneg);
        logic [63:0] m64;
        logic        big;
        m64 = 64'(mag);
        big = |m64[63:31];
        if (dneg)
            return big ? 32'sh7fffffff : $signed(m64[31:0]);
        else
            return big ? 32'sh80000000 : $signed(-m64[31:0]);
    endfunction

    logic           adv;
    logic           load;
    logic [LAT-1:0] vld_reg;

    htm_pkg::vec_t p_in, q_in;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            p_in[i] = s_axis_tdata[32*i +: 32];
            q_in[i] = s_axis_tdata[128 + 32*i +: 32];
        end
    end

    // stage A: Minkowski partial products
    prod_t pq_a_reg [4], pp_a_reg [4], qq_a_reg [4];
    htm_pkg::vec_t p_a_reg, q_a_reg;
    // stage B: Minkowski sums
    htm_pkg::word_t pq_b_reg, pp_b_reg, qq_b_reg;
    htm_pkg::vec_t  p_b_reg, q_b_reg;
    // stage C: weight products
    prod_t t1_c_reg, t2_c_reg;
    htm_pkg::vec_t  p_c_reg, q_c_reg;
    htm_pkg::word_t pp_c_reg;
    // stage D: radicands
    logic [RADW-1:0] rad1_d_reg, rad2_d_reg;
    logic            fault_d_reg;
    htm_pkg::vec_t   p_d_reg, q_d_reg;
    htm_pkg::word_t  pp_d_reg;
    // alongside the square root
    htm_pkg::vec_t   sp_reg [SQL], sq_reg [SQL];
    htm_pkg::word_t  spp_reg [SQL];
    logic [SQL-1:0]  sf_reg;
    logic [SQL-1:0]  root1, root2;
    // stage E..H: midpoint and its norm
    prod_t mp_e_reg [4], mq_e_reg [4];
    htm_pkg::vec_t  p_e_reg;
    htm_pkg::word_t pp_e_reg;
    logic           fault_e_reg;
    htm_pkg::vec_t  m_f_reg, p_f_reg;
    htm_pkg::word_t pp_f_reg;
    logic           fault_f_reg;
    prod_t mm_g_reg [4];
    htm_pkg::vec_t  m_g_reg, p_g_reg;
    htm_pkg::word_t pp_g_reg;
    logic           fault_g_reg;
    logic [31:0]    dmm_h_reg, dmp_h_reg;
    logic           negm_h_reg, negp_h_reg, fault_h_reg;
    htm_pkg::vec_t  m_h_reg, p_h_reg;
    // alongside the reciprocal
    htm_pkg::vec_t  dm_reg [DVL], dp_reg [DVL];
    logic [DVL-1:0] dnm_reg, dnp_reg, df_reg;
    logic [DVL-1:0] quot_m, quot_p;
    // stage I..M: reflections and their product
    htm_pkg::mat_t  om_i_reg, op_i_reg;
    htm_pkg::word_t sm_i_reg, sp_i_reg;
    logic           fault_i_reg;
    prod_t em_j_reg [4][4], ep_j_reg [4][4];
    logic           fault_j_reg;
    htm_pkg::mat_t  ra_k_reg, rb_k_reg;
    logic           fault_k_reg;
    prod_t pt_l_reg [4][4][4];
    logic           fault_l_reg;
    htm_pkg::mat_t  ent_m_reg;
    logic           fault_m_reg;
    // row serialiser
    htm_pkg::mat_t  mat_reg;
    logic           sfault_reg;
    logic [1:0]     row_reg, row_next;
    logic           ovld_reg, ovld_next;

    // combinational stage work
    htm_pkg::word_t  v1_d, v2_d;
    logic [RADW-1:0] rad1_d, rad2_d;
    htm_pkg::word_t  dm_h;
    htm_pkg::mat_t   om_i, op_i, ra_k, rb_k, ent_m;

    always_comb
    begin
        v1_d   = htm_pkg::sat32(sx(t1_c_reg));
        v2_d   = htm_pkg::sat32(sx(t2_c_reg));
        rad1_d = v1_d[31] ? '0 : (RADW'(v1_d[30:0]) << FRAC_BITS);
        rad2_d = v2_d[31] ? '0 : (RADW'(v2_d[30:0]) << FRAC_BITS);
        dm_h   = mink(mm_g_reg);
    end

    // outer products x_i * x_j, sign of the timelike column flipped
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                om_i[i][j] = htm_pkg::sat32(htm_pkg::mulr(dm_reg[DVL-1][i],
                                                          dm_reg[DVL-1][j], FRAC_BITS));
                op_i[i][j] = htm_pkg::sat32(htm_pkg::mulr(dp_reg[DVL-1][i],
                                                          dp_reg[DVL-1][j], FRAC_BITS));
                if (j == 3)
                begin
                    om_i[i][j] = htm_pkg::neg_sat(om_i[i][j]);
                    op_i[i][j] = htm_pkg::neg_sat(op_i[i][j]);
                end
            end
        end
    end

    // saturate the scaled entries, then add one on the diagonal
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                ra_k[i][j] = htm_pkg::sat32(sx(em_j_reg[i][j]));
                rb_k[i][j] = htm_pkg::sat32(sx(ep_j_reg[i][j]));
                if (i == j)
                begin
                    ra_k[i][j] = htm_pkg::sat32(64'(ra_k[i][j]) + ONE64);
                    rb_k[i][j] = htm_pkg::sat32(64'(rb_k[i][j]) + ONE64);
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                ent_m[i][k] = fault_l_reg ? '0 :
                    htm_pkg::sat32(sx(pt_l_reg[i][k][0]) + sx(pt_l_reg[i][k][1])
                                 + sx(pt_l_reg[i][k][2]) + sx(pt_l_reg[i][k][3]));
            end
        end
    end

    htm_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_p (
        .clk  (clk),
        .en   (adv),
        .rad  (rad1_d_reg),
        .root (root1)
    );

    htm_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_q (
        .clk  (clk),
        .en   (adv),
        .rad  (rad2_d_reg),
        .root (root2)
    );

    htm_div #(.FRAC_BITS(FRAC_BITS)) u_div_m (
        .clk     (clk),
        .en      (adv),
        .divisor (dmm_h_reg),
        .quot    (quot_m)
    );

    htm_div #(.FRAC_BITS(FRAC_BITS)) u_div_p (
        .clk     (clk),
        .en      (adv),
        .divisor (dmp_h_reg),
        .quot    (quot_p)
    );

    // datapath registers: advance together, hold on stall
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                pq_a_reg[i] <= PW'(htm_pkg::mulr(p_in[i], q_in[i], FRAC_BITS));
                pp_a_reg[i] <= PW'(htm_pkg::mulr(p_in[i], p_in[i], FRAC_BITS));
                qq_a_reg[i] <= PW'(htm_pkg::mulr(q_in[i], q_in[i], FRAC_BITS));
            end
            p_a_reg <= p_in;
            q_a_reg <= q_in;

            pq_b_reg <= mink(pq_a_reg);
            pp_b_reg <= mink(pp_a_reg);
            qq_b_reg <= mink(qq_a_reg);
            p_b_reg  <= p_a_reg;
            q_b_reg  <= q_a_reg;

            t1_c_reg <= PW'(htm_pkg::mulr(qq_b_reg, pq_b_reg, FRAC_BITS));
            t2_c_reg <= PW'(htm_pkg::mulr(pp_b_reg, pq_b_reg, FRAC_BITS));
            p_c_reg  <= p_b_reg;
            q_c_reg  <= q_b_reg;
            pp_c_reg <= pp_b_reg;

            rad1_d_reg  <= rad1_d;
            rad2_d_reg  <= rad2_d;
            fault_d_reg <= v1_d[31] | v2_d[31];
            p_d_reg     <= p_c_reg;
            q_d_reg     <= q_c_reg;
            pp_d_reg    <= pp_c_reg;

            sp_reg[0]  <= p_d_reg;
            sq_reg[0]  <= q_d_reg;
            spp_reg[0] <= pp_d_reg;
            for (int k = 1; k < SQL; k++)
            begin
                sp_reg[k]  <= sp_reg[k-1];
                sq_reg[k]  <= sq_reg[k-1];
                spp_reg[k] <= spp_reg[k-1];
            end
            sf_reg <= {sf_reg[SQL-2:0], fault_d_reg};

            for (int i = 0; i < 4; i++)
            begin
                mp_e_reg[i] <= PW'(htm_pkg::mulr(32'(root1), sp_reg[SQL-1][i], FRAC_BITS));
                mq_e_reg[i] <= PW'(htm_pkg::mulr(32'(root2), sq_reg[SQL-1][i], FRAC_BITS));
            end
            p_e_reg     <= sp_reg[SQL-1];
            pp_e_reg    <= spp_reg[SQL-1];
            fault_e_reg <= sf_reg[SQL-1];

            for (int i = 0; i < 4; i++)
                m_f_reg[i] <= htm_pkg::sat32(sx(mp_e_reg[i]) + sx(mq_e_reg[i]));
            p_f_reg     <= p_e_reg;
            pp_f_reg    <= pp_e_reg;
            fault_f_reg <= fault_e_reg;

            for (int i = 0; i < 4; i++)
                mm_g_reg[i] <= PW'(htm_pkg::mulr(m_f_reg[i], m_f_reg[i], FRAC_BITS));
            m_g_reg     <= m_f_reg;
            p_g_reg     <= p_f_reg;
            pp_g_reg    <= pp_f_reg;
            fault_g_reg <= fault_f_reg;

            dmm_h_reg   <= dm_h[31] ? 32'(-dm_h) : 32'(dm_h);
            dmp_h_reg   <= pp_g_reg[31] ? 32'(-pp_g_reg) : 32'(pp_g_reg);
            negm_h_reg  <= dm_h[31];
            negp_h_reg  <= pp_g_reg[31];
            fault_h_reg <= fault_g_reg | (dm_h == '0) | (pp_g_reg == '0);
            m_h_reg     <= m_g_reg;
            p_h_reg     <= p_g_reg;

            dm_reg[0] <= m_h_reg;
            dp_reg[0] <= p_h_reg;
            for (int k = 1; k < DVL; k++)
            begin
                dm_reg[k] <= dm_reg[k-1];
                dp_reg[k] <= dp_reg[k-1];
            end
            dnm_reg <= {dnm_reg[DVL-2:0], negm_h_reg};
            dnp_reg <= {dnp_reg[DVL-2:0], negp_h_reg};
            df_reg  <= {df_reg[DVL-2:0], fault_h_reg};

            om_i_reg    <= om_i;
            op_i_reg    <= op_i;
            sm_i_reg    <= to_scale(quot_m, dnm_reg[DVL-1]);
            sp_i_reg    <= to_scale(quot_p, dnp_reg[DVL-1]);
            fault_i_reg <= df_reg[DVL-1];

            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    em_j_reg[i][j] <= PW'(htm_pkg::mulr(om_i_reg[i][j], sm_i_reg, FRAC_BITS));
                    ep_j_reg[i][j] <= PW'(htm_pkg::mulr(op_i_reg[i][j], sp_i_reg, FRAC_BITS));
                end
            end
            fault_j_reg <= fault_i_reg;

            ra_k_reg    <= ra_k;
            rb_k_reg    <= rb_k;
            fault_k_reg <= fault_j_reg;

            for (int i = 0; i < 4; i++)
                for (int k = 0; k < 4; k++)
                    for (int j = 0; j < 4; j++)
                        pt_l_reg[i][k][j] <= PW'(htm_pkg::mulr(ra_k_reg[i][j],
                                                               rb_k_reg[j][k], FRAC_BITS));
            fault_l_reg <= fault_k_reg;

            ent_m_reg   <= ent_m;
            fault_m_reg <= fault_l_reg;
        end
    end

    // advance unless a finished matrix waits on a serialiser that is not freeing up
    assign adv  = !vld_reg[LAT-1] || !ovld_reg
                  || (m_axis_tready && (row_reg == htm_pkg::ROW_LAST));
    assign load = adv && vld_reg[LAT-1];
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
    end

    always_comb
    begin
        row_next  = row_reg;
        ovld_next = ovld_reg;
        priority if (load)
        begin
            row_next  = '0;
            ovld_next = 1'b1;
        end
        else if (ovld_reg && m_axis_tready)
        begin
            if (row_reg == htm_pkg::ROW_LAST)
                ovld_next = 1'b0;
            else
                row_next = row_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            ovld_reg <= 1'b0;
        end
        else
        begin
            row_reg  <= row_next;
            ovld_reg <= ovld_next;
        end
    end

    // hold the whole matrix; rows are picked out by the counter
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mat_reg    <= ent_m_reg;
            sfault_reg <= fault_m_reg;
        end
    end

    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tdata  = {mat_reg[row_reg][3], mat_reg[row_reg][2],
                            mat_reg[row_reg][1], mat_reg[row_reg][0]};
    assign m_axis_tuser  = {sfault_reg, row_reg};
    assign m_axis_tlast  = (row_reg == htm_pkg::ROW_LAST);

    `HTM_ASSERT_NXT(a_row_step, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (row_reg == 2'($past(row_reg) + 2'd1)), "row did not advance after a transfer")
    `HTM_ASSERT_NXT(a_hold_item, vld_reg[LAT-1] && !adv, vld_reg[LAT-1], "finished matrix dropped during stall")
    `HTM_ASSERT_IMP(a_fault_zero, m_axis_tvalid && m_axis_tuser[2], m_axis_tdata == '0, "faulted row carries non-zero entries")

endmodule
